@@ design/smo_pkg.sv @@
`timescale 1ns / 1ps

package smo_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int DATA_W  = 32;
  localparam int DIM_W   = 4;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LOAD_W  = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic complete;
    logic last;
  } dp_stat_t;

  // Map a dimension register onto 1..max.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ design/smo_ram.sv @@
`timescale 1ns / 1ps

module smo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/smo_ctrl.sv @@
`timescale 1ns / 1ps

module smo_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  smo_pkg::dp_stat_t  stat,
  output smo_pkg::ctrl_cmd_t cmd,
  output logic               busy
);

  smo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smo_pkg::ST_IDLE: begin
        if (start && stat.complete) begin
          state_nxt = smo_pkg::ST_EMIT;
        end
      end
      smo_pkg::ST_EMIT: begin
        if (stat.last) begin
          state_nxt = smo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      smo_pkg::ST_IDLE: begin
        cmd.load = start;
        cmd.init = start && stat.complete;
      end
      smo_pkg::ST_EMIT: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ design/smo_dp.sv @@
`timescale 1ns / 1ps

module smo_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [smo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smo_pkg::DIM_W-1:0]         cfg_data,
  input  logic signed [smo_pkg::DATA_W-1:0] in_element_value,
  input  smo_pkg::ctrl_cmd_t                cmd,
  output smo_pkg::dp_stat_t                 stat,
  output logic                              out_strobe,
  output logic signed [smo_pkg::DATA_W-1:0] out_spiral_value,
  output logic                              out_final_flag
);

  logic [smo_pkg::DIM_W-1:0]  rows_r, cols_r;
  logic [smo_pkg::DIM_W-1:0]  rows_eff, cols_eff;
  logic [2*smo_pkg::DIM_W-1:0] total_prod;
  logic [smo_pkg::LOAD_W-1:0] total;
  logic [smo_pkg::LOAD_W-1:0] load_cnt_r, load_cnt_nxt, load_inc;
  logic [smo_pkg::LOAD_W-1:0] remain_r, remain_nxt;
  logic [smo_pkg::ROW_W-1:0]  row_r, row_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [smo_pkg::COL_W-1:0]  col_r, col_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  smo_pkg::dir_t              dir_r, dir_nxt;
  logic                       strobe_r, final_r;
  logic                       ram_we;
  logic [smo_pkg::ADDR_W-1:0] rd_addr;
  logic [smo_pkg::ROW_W+smo_pkg::DIM_W-1:0] addr_prod, addr_sum;
  logic [smo_pkg::DATA_W-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= smo_pkg::DIM_W'(1);
      cols_r <= smo_pkg::DIM_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        smo_pkg::REG_ROW_COUNT:    rows_r <= cfg_data;
        smo_pkg::REG_COLUMN_COUNT: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_eff   = smo_pkg::clamp_dim(rows_r, smo_pkg::MAX_ROWS);
  assign cols_eff   = smo_pkg::clamp_dim(cols_r, smo_pkg::MAX_COLS);
  assign total_prod = {{smo_pkg::DIM_W{1'b0}}, rows_eff} * {{smo_pkg::DIM_W{1'b0}}, cols_eff};
  assign total      = smo_pkg::LOAD_W'(total_prod);

  // Load counter; last word of the spiral when one step remains
  assign load_inc = load_cnt_r + smo_pkg::LOAD_W'(1);
  assign stat     = '{complete: (load_inc >= total),
                      last:     (remain_r == smo_pkg::LOAD_W'(1))};
  assign ram_we   = cmd.load && (load_cnt_r < smo_pkg::LOAD_W'(smo_pkg::STORE_DEPTH));

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (cmd.load) begin
      load_cnt_nxt = stat.complete ? '0 : load_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

  // Spiral walker: shrink the bounding box after each side is done
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    lft_nxt    = lft_r;
    rgt_nxt    = rgt_r;
    dir_nxt    = dir_r;
    remain_nxt = remain_r;
    if (cmd.init) begin
      row_nxt    = '0;
      col_nxt    = '0;
      top_nxt    = '0;
      lft_nxt    = '0;
      bot_nxt    = smo_pkg::ROW_W'(rows_eff - smo_pkg::DIM_W'(1));
      rgt_nxt    = smo_pkg::COL_W'(cols_eff - smo_pkg::DIM_W'(1));
      dir_nxt    = smo_pkg::DIR_RIGHT;
      remain_nxt = total;
    end else if (cmd.step) begin
      remain_nxt = remain_r - smo_pkg::LOAD_W'(1);
      case (dir_r)
        smo_pkg::DIR_RIGHT: begin
          if (col_r == rgt_r) begin
            top_nxt = top_r + smo_pkg::ROW_W'(1);
            row_nxt = row_r + smo_pkg::ROW_W'(1);
            dir_nxt = smo_pkg::DIR_DOWN;
          end else begin
            col_nxt = col_r + smo_pkg::COL_W'(1);
          end
        end
        smo_pkg::DIR_DOWN: begin
          if (row_r == bot_r) begin
            rgt_nxt = rgt_r - smo_pkg::COL_W'(1);
            col_nxt = col_r - smo_pkg::COL_W'(1);
            dir_nxt = smo_pkg::DIR_LEFT;
          end else begin
            row_nxt = row_r + smo_pkg::ROW_W'(1);
          end
        end
        smo_pkg::DIR_LEFT: begin
          if (col_r == lft_r) begin
            bot_nxt = bot_r - smo_pkg::ROW_W'(1);
            row_nxt = row_r - smo_pkg::ROW_W'(1);
            dir_nxt = smo_pkg::DIR_UP;
          end else begin
            col_nxt = col_r - smo_pkg::COL_W'(1);
          end
        end
        default: begin
          if (row_r == top_r) begin
            lft_nxt = lft_r + smo_pkg::COL_W'(1);
            col_nxt = col_r + smo_pkg::COL_W'(1);
            dir_nxt = smo_pkg::DIR_RIGHT;
          end else begin
            row_nxt = row_r - smo_pkg::ROW_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    top_r    <= top_nxt;
    bot_r    <= bot_nxt;
    lft_r    <= lft_nxt;
    rgt_r    <= rgt_nxt;
    dir_r    <= dir_nxt;
    remain_r <= remain_nxt;
  end

  // Row-major address of the current position
  assign addr_prod = {{smo_pkg::DIM_W{1'b0}}, row_r} * {{smo_pkg::ROW_W{1'b0}}, cols_eff};
  assign addr_sum  = addr_prod + (smo_pkg::ROW_W + smo_pkg::DIM_W)'(col_r);
  assign rd_addr   = addr_sum[smo_pkg::ADDR_W-1:0];

  smo_ram #(
    .WIDTH (smo_pkg::DATA_W),
    .DEPTH (smo_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_cnt_r[smo_pkg::ADDR_W-1:0]),
    .wdata (in_element_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Strobe is registered from the step, in the cycle after the read, to line up with the RAM output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.step;
      final_r  <= cmd.step && stat.last;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_final_flag   = final_r;
  assign out_spiral_value = $signed(rd_data);

endmodule

@@ design/spiral_matrix_order.sv @@
`timescale 1ns / 1ps

// Spiral matrix reorder.
// Input: one matrix element per word in row-major order, taken at a rising
// edge where start is high and busy is low. When rows*cols words have arrived,
// busy rises while a walker steps through the element store clockwise, ring
// by ring from the outside in, issuing one store read per cycle.
// Output: each word appears on out_spiral_value for one cycle with out_strobe
// high, in the cycle after its read; out_final_flag marks the last word. The
// first result shows once the controller has entered its emit state and the
// first store read has been registered. A new matrix cannot load while one is
// emitted, since there is a single element store: it must be drained before
// the next matrix may overwrite it.
// Dimensions come from cfg writes (index 0 rows, 1 columns, 1..8; zero reads
// as one, larger as eight); write them only while the block is idle.
// Reset clears the load count and sets both dimensions to one; store contents
// are not cleared. The receiver cannot stall: results must be taken as shown.
module spiral_matrix_order (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [smo_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_strobe,
  output logic signed [smo_pkg::DATA_W-1:0] out_spiral_value,
  output logic                              out_final_flag,
  input  logic                              cfg_write_en,
  input  logic [smo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smo_pkg::DIM_W-1:0]         cfg_data
);

  smo_pkg::ctrl_cmd_t cmd;
  smo_pkg::dp_stat_t  stat;

  smo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  smo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_spiral_value (out_spiral_value),
    .out_final_flag   (out_final_flag)
  );

endmodule

@@ design/smo_checker.sv @@
`timescale 1ns / 1ps

module smo_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_final_flag
);

  // Final flag never appears without a word
  a_final_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_flag |-> out_strobe)
    else $error("final flag without strobe");

  // Nothing follows the final word in the next cycle
  a_gap_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_flag |=> !out_strobe)
    else $error("word right after final");

  // Emission starts only from an accepted word
  a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without accepted word");

  // Every emitting cycle yields a word in the cycle after
  a_busy_yields_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe)
    else $error("emit cycle without word");

  // First emitting cycle carries no word yet
  a_no_word_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_strobe)
    else $error("word on first emit cycle");

endmodule

bind spiral_matrix_order smo_checker u_smo_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_final_flag (out_final_flag)
);
